// ===== src/rsf_pkg.sv =====
`default_nettype none
package rsf_pkg;

    localparam int DIR_FRAC_BITS = 16;

    localparam int POS_W  = 32;
    localparam int DIR_W  = 18;
    localparam int RAD_W  = 31;
    localparam int V_W    = POS_W + 1;
    localparam int SQ_W   = 2 * V_W;
    localparam int VV_W   = SQ_W;
    localparam int RR_W   = 2 * RAD_W;
    localparam int BP_W   = V_W + DIR_W;
    localparam int B_W    = BP_W + 1;
    localparam int BH_W   = B_W / 2;
    localparam int PP_W   = 2 * BH_W;

    localparam int SQ_IN_W   = 102;
    localparam int SQ_ROOT_W = SQ_IN_W / 2;
    localparam int SQ_REM_W  = SQ_ROOT_W + 4;

    localparam int T0F_W  = B_W + 2;
    localparam int PROD_W = DIR_W + POS_W;
    localparam int N_W    = PROD_W - DIR_FRAC_BITS + 1;
    localparam int A_W    = 31;
    localparam int ASQ_W  = 2 * A_W;
    localparam int SUM_W  = 64;
    localparam int SH_W   = 3;

    localparam int NUM_W    = A_W + DIR_FRAC_BITS;
    localparam int NQ_W     = DIR_W;
    localparam int DEN_W    = 32;
    localparam int DV_CMP_W = DEN_W + NQ_W;
    localparam int DVJ_W    = $clog2(NQ_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = POS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;

    localparam logic [RAD_W-1:0] RADIUS_RST = 31'd65536;

    localparam logic [POS_W-1:0] T_MAX = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] T_MIN = 32'h8000_0000;

    localparam logic [DIR_W-1:0] NRM_MAX     = 18'h1FFFF;
    localparam logic [DIR_W-1:0] NRM_MIN     = 18'h20000;
    localparam logic [NQ_W-1:0]  NRM_POS_LIM = 18'd131071;
    localparam logic [NQ_W-1:0]  NRM_NEG_LIM = 18'd131072;

    typedef struct packed {
        logic                      ok;
        logic [B_W-1:0]            b;
        logic [2:0][V_W-1:0]       v;
        logic [2:0][DIR_W-1:0]     d;
        logic [POS_W-1:0]          tn;
        logic [POS_W-1:0]          tf;
    } t_sb1;

    localparam int SB_W = $bits(t_sb1);

    typedef struct packed {
        logic                  hit;
        logic [POS_W-1:0]      hdist;
        logic [2:0]            neg;
        logic [2:0][A_W-1:0]   a;
    } t_sb2;

    localparam int SB2_W = $bits(t_sb2);

    typedef struct packed {
        logic [SQ_IN_W-1:0]   rad;
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
    } t_sq_st;

    typedef struct packed {
        logic [2:0][NUM_W-1:0] rem;
        logic [2:0][NQ_W-1:0]  q;
    } t_dv_st;

    typedef struct packed {
        logic              hit;
        logic [POS_W-1:0]  hdist;
        logic [2:0]        neg;
        logic [2:0]        big;
        logic              zero;
        logic [DEN_W-1:0]  den;
    } t_dv_sb;

    // one result bit of the floor square root
    function automatic t_sq_st sq_step(input t_sq_st s);
        t_sq_st o;
        logic [SQ_REM_W-1:0] acc;
        logic [SQ_REM_W-1:0] trial;
        acc   = {s.rem[SQ_REM_W-3:0], s.rad[SQ_IN_W-1 -: 2]};
        trial = SQ_REM_W'({s.root, 2'b01});
        o.rad = {s.rad[SQ_IN_W-3:0], 2'b00};
        if (acc >= trial) begin
            o.rem  = acc - trial;
            o.root = {s.root[SQ_ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = acc;
            o.root = {s.root[SQ_ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // one quotient bit on all three lanes
    function automatic t_dv_st dv_step(input t_dv_st s, input logic [DEN_W-1:0] den,
                                       input logic [DVJ_W-1:0] j);
        t_dv_st o;
        logic [DV_CMP_W-1:0] sh;
        o  = s;
        sh = DV_CMP_W'(den) << j;
        for (int l = 0; l < 3; l++) begin
            if (DV_CMP_W'(s.rem[l]) >= sh) begin
                o.rem[l]    = s.rem[l] - NUM_W'(sh);
                o.q[l][j]   = 1'b1;
            end
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// ===== src/rsf_isqrt.sv =====
`default_nettype none
module rsf_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [rsf_pkg::SQ_IN_W-1:0]   i_rad,
    input  logic [rsf_pkg::SB_W-1:0]      i_sb,
    output logic                          o_vld,
    output logic [rsf_pkg::SQ_ROOT_W-1:0] o_root,
    output logic [rsf_pkg::SB_W-1:0]      o_sb
);
    localparam int NST = rsf_pkg::SQ_ROOT_W;

    logic [NST-1:0]              r_vld;
    rsf_pkg::t_sq_st             r_st [NST];
    rsf_pkg::t_sq_st             n_st [NST];
    logic [rsf_pkg::SB_W-1:0]    r_sb [NST];

    always_comb begin
        n_st[0] = rsf_pkg::sq_step(rsf_pkg::t_sq_st'{rad: i_rad, rem: '0, root: '0});
        for (int k = 1; k < NST; k++) begin
            n_st[k] = rsf_pkg::sq_step(r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb[0] <= i_sb;
            for (int k = 0; k < NST; k++) begin
                r_st[k] <= n_st[k];
            end
            for (int k = 1; k < NST; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    assign o_vld  = r_vld[NST-1];
    assign o_root = r_st[NST-1].root;
    assign o_sb   = r_sb[NST-1];

endmodule
`default_nettype wire

// ===== src/rsf_front.sv =====
`default_nettype none
module rsf_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic signed [rsf_pkg::POS_W-1:0]  i_origin_x,
    input  logic signed [rsf_pkg::POS_W-1:0]  i_origin_y,
    input  logic signed [rsf_pkg::POS_W-1:0]  i_origin_z,
    input  logic signed [rsf_pkg::DIR_W-1:0]  i_dir_x,
    input  logic signed [rsf_pkg::DIR_W-1:0]  i_dir_y,
    input  logic signed [rsf_pkg::DIR_W-1:0]  i_dir_z,
    input  logic signed [rsf_pkg::POS_W-1:0]  i_t_near,
    input  logic signed [rsf_pkg::POS_W-1:0]  i_t_far,
    input  logic                              i_light_mask_set,
    input  logic                              i_ray_valid,
    input  logic signed [rsf_pkg::POS_W-1:0]  i_center_x,
    input  logic signed [rsf_pkg::POS_W-1:0]  i_center_y,
    input  logic signed [rsf_pkg::POS_W-1:0]  i_center_z,
    input  logic        [rsf_pkg::RAD_W-1:0]  i_sphere_radius,
    output logic                              o_vld,
    output logic        [rsf_pkg::SQ_IN_W-1:0] o_disc,
    output logic        [rsf_pkg::SB_W-1:0]   o_sb
);
    localparam int V_W   = rsf_pkg::V_W;
    localparam int DIR_W = rsf_pkg::DIR_W;
    localparam int POS_W = rsf_pkg::POS_W;

    logic [6:0] r_vld;

    // stage 1: offset from centre
    logic signed [V_W-1:0]   n1_v [3];
    logic signed [V_W-1:0]   r1_v [3];
    logic signed [DIR_W-1:0] r1_d [3];
    logic [POS_W-1:0]        r1_tn, r1_tf;
    logic                    r1_ok;

    // stage 2: products
    logic [rsf_pkg::SQ_W-1:0]        n2_sq [3];
    logic signed [rsf_pkg::BP_W-1:0] n2_bp [3];
    logic [rsf_pkg::RR_W-1:0]        n2_rr;
    logic [rsf_pkg::SQ_W-1:0]        r2_sq [3];
    logic signed [rsf_pkg::BP_W-1:0] r2_bp [3];
    logic [rsf_pkg::RR_W-1:0]        r2_rr;
    logic signed [V_W-1:0]           r2_v [3];
    logic signed [DIR_W-1:0]         r2_d [3];
    logic [POS_W-1:0]                r2_tn, r2_tf;
    logic                            r2_ok;

    // stage 3: sums
    logic [rsf_pkg::VV_W-1:0] n3_vv, r3_vv;
    logic [rsf_pkg::RR_W-1:0] r3_rr;
    rsf_pkg::t_sb1            n3_sb, r3_sb;

    // stage 4: c and |b| halves
    logic [rsf_pkg::VV_W:0]     n4_diff;
    logic [rsf_pkg::B_W-1:0]    n4_bm;
    rsf_pkg::t_sb1              n4_sb, r4_sb;
    logic [rsf_pkg::VV_W-1:0]   r4_c;
    logic [rsf_pkg::BH_W-1:0]   r4_bh, r4_bl;

    // stage 5: partial products of b*b
    logic [rsf_pkg::PP_W-1:0]   r5_hh, r5_hl, r5_ll;
    logic [rsf_pkg::VV_W-1:0]   r5_c;
    rsf_pkg::t_sb1              r5_sb;

    // stage 6 and 7: discriminant
    logic [rsf_pkg::SQ_IN_W-1:0] n6_bb, n6_cs, r6_bb, r6_cs;
    rsf_pkg::t_sb1               r6_sb, n7_sb, r7_sb;
    logic                        n7_bor;
    logic [rsf_pkg::SQ_IN_W-1:0] n7_disc, r7_disc;

    always_comb begin
        n1_v[0] = V_W'(i_origin_x) - V_W'(i_center_x);
        n1_v[1] = V_W'(i_origin_y) - V_W'(i_center_y);
        n1_v[2] = V_W'(i_origin_z) - V_W'(i_center_z);

        for (int i = 0; i < 3; i++) begin
            n2_sq[i] = r1_v[i] * r1_v[i];
            n2_bp[i] = r1_v[i] * r1_d[i];
        end
        n2_rr = i_sphere_radius * i_sphere_radius;

        n3_vv = r2_sq[0] + r2_sq[1] + r2_sq[2];
        n3_sb.b  = r2_bp[0] + r2_bp[1] + r2_bp[2];
        n3_sb.ok = r2_ok;
        n3_sb.tn = r2_tn;
        n3_sb.tf = r2_tf;
        for (int i = 0; i < 3; i++) begin
            n3_sb.v[i] = r2_v[i];
            n3_sb.d[i] = r2_d[i];
        end

        // a borrow here means the origin lies inside the sphere
        n4_diff  = {1'b0, r3_vv} - (rsf_pkg::VV_W + 1)'(r3_rr);
        n4_sb    = r3_sb;
        n4_sb.ok = r3_sb.ok & ~n4_diff[rsf_pkg::VV_W];
        n4_bm    = r3_sb.b[rsf_pkg::B_W-1] ? -r3_sb.b : r3_sb.b;

        n6_bb = (rsf_pkg::SQ_IN_W'(r5_hh) << (2 * rsf_pkg::BH_W))
              + (rsf_pkg::SQ_IN_W'(r5_hl) << (rsf_pkg::BH_W + 1))
              + rsf_pkg::SQ_IN_W'(r5_ll);
        n6_cs = rsf_pkg::SQ_IN_W'(r5_c) << (2 * rsf_pkg::DIR_FRAC_BITS);

        {n7_bor, n7_disc} = {1'b0, r6_bb} - {1'b0, r6_cs};
        n7_sb    = r6_sb;
        n7_sb.ok = r6_sb.ok & ~n7_bor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_v[i]  <= n1_v[i];
                r2_sq[i] <= n2_sq[i];
                r2_bp[i] <= n2_bp[i];
                r2_v[i]  <= r1_v[i];
                r2_d[i]  <= r1_d[i];
            end
            r1_d[0] <= i_dir_x;
            r1_d[1] <= i_dir_y;
            r1_d[2] <= i_dir_z;
            r1_tn   <= i_t_near;
            r1_tf   <= i_t_far;
            r1_ok   <= i_ray_valid & i_light_mask_set;

            r2_rr <= n2_rr;
            r2_tn <= r1_tn;
            r2_tf <= r1_tf;
            r2_ok <= r1_ok;

            r3_vv <= n3_vv;
            r3_rr <= r2_rr;
            r3_sb <= n3_sb;

            r4_sb <= n4_sb;
            r4_c  <= n4_diff[rsf_pkg::VV_W-1:0];
            r4_bh <= n4_bm[rsf_pkg::B_W-1 -: rsf_pkg::BH_W];
            r4_bl <= n4_bm[rsf_pkg::BH_W-1:0];

            r5_hh <= r4_bh * r4_bh;
            r5_hl <= r4_bh * r4_bl;
            r5_ll <= r4_bl * r4_bl;
            r5_c  <= r4_c;
            r5_sb <= r4_sb;

            r6_bb <= n6_bb;
            r6_cs <= n6_cs;
            r6_sb <= r5_sb;

            r7_disc <= n7_disc;
            r7_sb   <= n7_sb;
        end
    end

    assign o_vld  = r_vld[6];
    assign o_disc = r7_disc;
    assign o_sb   = rsf_pkg::SB_W'(r7_sb);

endmodule
`default_nettype wire

// ===== src/rsf_prep.sv =====
`default_nettype none
module rsf_prep (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [rsf_pkg::SQ_ROOT_W-1:0] i_root,
    input  logic [rsf_pkg::SB_W-1:0]      i_sb,
    output logic                          o_vld,
    output logic [rsf_pkg::SQ_IN_W-1:0]   o_rad,
    output logic [rsf_pkg::SB_W-1:0]      o_sb
);
    localparam int POS_W = rsf_pkg::POS_W;
    localparam int T0F_W = rsf_pkg::T0F_W;
    localparam int N_W   = rsf_pkg::N_W;
    localparam int A_W   = rsf_pkg::A_W;

    rsf_pkg::t_sb1 sb_in;
    logic [5:0]    r_vld;

    // stage 1: near root, floored and saturated
    logic signed [T0F_W-1:0] n1_t0f, n1_t0s;
    logic                    n1_rng;
    logic [POS_W-1:0]        n1_t0;
    logic signed [POS_W-1:0] r1_t0;
    rsf_pkg::t_sb1           r1_sb;

    // stage 2: bounds and dir * t0
    logic                               n2_hit;
    logic signed [rsf_pkg::PROD_W-1:0]  n2_prod [3];
    logic signed [rsf_pkg::PROD_W-1:0]  r2_prod [3];
    logic signed [rsf_pkg::V_W-1:0]     r2_v [3];
    logic                               r2_hit;
    logic [POS_W-1:0]                   r2_dist;

    // stage 3: hit offset
    logic signed [N_W-1:0] n3_n [3];
    logic [N_W-1:0]        r3_a [3];
    logic [2:0]            r3_neg;
    logic                  r3_hit;
    logic [POS_W-1:0]      r3_dist;

    // stage 4: common scale
    logic [N_W-1:0]            n4_or;
    logic [rsf_pkg::SH_W-1:0]  n4_sh;
    rsf_pkg::t_sb2             n4_sb, r4_sb, r5_sb, r6_sb;

    logic [rsf_pkg::ASQ_W-1:0] r5_sq [3];
    logic [rsf_pkg::SUM_W-1:0] r6_sum;

    always_comb begin
        sb_in = rsf_pkg::t_sb1'(i_sb);

        n1_t0f = -T0F_W'(signed'(sb_in.b)) - T0F_W'(i_root);
        n1_t0s = n1_t0f >>> rsf_pkg::DIR_FRAC_BITS;
        n1_rng = (n1_t0s[T0F_W-1:POS_W-1] == '0) || (n1_t0s[T0F_W-1:POS_W-1] == '1);
        if (n1_rng) begin
            n1_t0 = n1_t0s[POS_W-1:0];
        end else if (n1_t0s[T0F_W-1]) begin
            n1_t0 = rsf_pkg::T_MIN;
        end else begin
            n1_t0 = rsf_pkg::T_MAX;
        end

        n2_hit = r1_sb.ok && ($signed(r1_sb.tn) < r1_t0) && (r1_t0 < $signed(r1_sb.tf));
        for (int i = 0; i < 3; i++) begin
            n2_prod[i] = $signed(r1_sb.d[i]) * r1_t0;
            n3_n[i]    = N_W'(r2_v[i]) + N_W'(r2_prod[i] >>> rsf_pkg::DIR_FRAC_BITS);
        end

        n4_or = r3_a[0] | r3_a[1] | r3_a[2];
        priority if (n4_or[N_W-1]) n4_sh = 3'd4;
        else if (n4_or[N_W-2])     n4_sh = 3'd3;
        else if (n4_or[N_W-3])     n4_sh = 3'd2;
        else if (n4_or[N_W-4])     n4_sh = 3'd1;
        else                       n4_sh = 3'd0;
        n4_sb.hit   = r3_hit;
        n4_sb.hdist = r3_dist;
        n4_sb.neg   = r3_neg;
        for (int i = 0; i < 3; i++) begin
            n4_sb.a[i] = A_W'(r3_a[i] >> n4_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t0 <= n1_t0;
            r1_sb <= sb_in;

            r2_hit  <= n2_hit;
            r2_dist <= n2_hit ? r1_t0 : r1_sb.tf;
            for (int i = 0; i < 3; i++) begin
                r2_prod[i] <= n2_prod[i];
                r2_v[i]    <= $signed(r1_sb.v[i]);
                r3_neg[i]  <= n3_n[i][N_W-1];
                r3_a[i]    <= n3_n[i][N_W-1] ? N_W'(-n3_n[i]) : N_W'(n3_n[i]);
                r5_sq[i]   <= r4_sb.a[i] * r4_sb.a[i];
            end
            r3_hit  <= r2_hit;
            r3_dist <= r2_dist;

            r4_sb  <= n4_sb;
            r5_sb  <= r4_sb;
            r6_sb  <= r5_sb;
            r6_sum <= rsf_pkg::SUM_W'(r5_sq[0]) + rsf_pkg::SUM_W'(r5_sq[1])
                    + rsf_pkg::SUM_W'(r5_sq[2]);
        end
    end

    assign o_vld = r_vld[5];
    assign o_rad = rsf_pkg::SQ_IN_W'(r6_sum);
    assign o_sb  = rsf_pkg::SB_W'(r6_sb);

endmodule
`default_nettype wire

// ===== src/rsf_div.sv =====
`default_nettype none
module rsf_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic [rsf_pkg::SQ_ROOT_W-1:0]     i_root,
    input  logic [rsf_pkg::SB_W-1:0]          i_sb,
    output logic                              o_vld,
    output logic                              o_hit,
    output logic signed [rsf_pkg::POS_W-1:0]  o_hit_distance,
    output logic signed [rsf_pkg::DIR_W-1:0]  o_normal_x,
    output logic signed [rsf_pkg::DIR_W-1:0]  o_normal_y,
    output logic signed [rsf_pkg::DIR_W-1:0]  o_normal_z
);
    localparam int NQ_W  = rsf_pkg::NQ_W;
    localparam int DIR_W = rsf_pkg::DIR_W;

    rsf_pkg::t_sb2   sb_in;
    rsf_pkg::t_dv_st n0_st, r0_st;
    rsf_pkg::t_dv_sb n0_sb, r0_sb;
    logic [rsf_pkg::NUM_W-1:0] n0_num [3];

    rsf_pkg::t_dv_st n_st [NQ_W];
    rsf_pkg::t_dv_st r_st [NQ_W];
    rsf_pkg::t_dv_sb r_dsb [NQ_W];
    logic [NQ_W+1:0] r_vld;

    rsf_pkg::t_dv_st  fin_st;
    rsf_pkg::t_dv_sb  fin_sb;
    logic [DIR_W-1:0] n_nrm [3];
    logic [DIR_W-1:0] r_nrm [3];
    logic             r_hit;
    logic [rsf_pkg::POS_W-1:0] r_dist;

    always_comb begin
        sb_in = rsf_pkg::t_sb2'(i_sb[rsf_pkg::SB2_W-1:0]);

        n0_sb.hit   = sb_in.hit;
        n0_sb.hdist = sb_in.hdist;
        n0_sb.neg   = sb_in.neg;
        n0_sb.den   = i_root[rsf_pkg::DEN_W-1:0];
        n0_sb.zero  = (i_root[rsf_pkg::DEN_W-1:0] == '0);
        for (int l = 0; l < 3; l++) begin
            n0_num[l]    = {sb_in.a[l], {rsf_pkg::DIR_FRAC_BITS{1'b0}}};
            // quotient would not fit the lane: saturate later
            n0_sb.big[l] = rsf_pkg::DV_CMP_W'(n0_num[l])
                         >= {i_root[rsf_pkg::DEN_W-1:0], {NQ_W{1'b0}}};
            n0_st.rem[l] = n0_num[l];
            n0_st.q[l]   = '0;
        end

        n_st[0] = rsf_pkg::dv_step(r0_st, r0_sb.den, rsf_pkg::DVJ_W'(NQ_W - 1));
        for (int k = 1; k < NQ_W; k++) begin
            n_st[k] = rsf_pkg::dv_step(r_st[k-1], r_dsb[k-1].den,
                                       rsf_pkg::DVJ_W'(NQ_W - 1 - k));
        end

        fin_st = r_st[NQ_W-1];
        fin_sb = r_dsb[NQ_W-1];
        for (int l = 0; l < 3; l++) begin
            if (!fin_sb.hit || fin_sb.zero) begin
                n_nrm[l] = '0;
            end else if (fin_sb.neg[l]) begin
                if (fin_sb.big[l] || fin_st.q[l] > rsf_pkg::NRM_NEG_LIM) begin
                    n_nrm[l] = rsf_pkg::NRM_MIN;
                end else begin
                    n_nrm[l] = -fin_st.q[l];
                end
            end else begin
                if (fin_sb.big[l] || fin_st.q[l] > rsf_pkg::NRM_POS_LIM) begin
                    n_nrm[l] = rsf_pkg::NRM_MAX;
                end else begin
                    n_nrm[l] = fin_st.q[l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NQ_W:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_st    <= n0_st;
            r0_sb    <= n0_sb;
            r_dsb[0] <= r0_sb;
            for (int k = 0; k < NQ_W; k++) begin
                r_st[k] <= n_st[k];
            end
            for (int k = 1; k < NQ_W; k++) begin
                r_dsb[k] <= r_dsb[k-1];
            end
            r_hit  <= fin_sb.hit;
            r_dist <= fin_sb.hdist;
            for (int l = 0; l < 3; l++) begin
                r_nrm[l] <= n_nrm[l];
            end
        end
    end

    assign o_vld          = r_vld[NQ_W+1];
    assign o_hit          = r_hit;
    assign o_hit_distance = r_dist;
    assign o_normal_x     = r_nrm[0];
    assign o_normal_y     = r_nrm[1];
    assign o_normal_z     = r_nrm[2];

endmodule
`default_nettype wire

// ===== src/ray_sphere_front_hit.sv =====
// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_ready      ray: origin, dir, t_near, t_far, flags
// out       output     o_out_valid / i_out_ready    hit, hit_distance, normal xyz
// cfg       input      i_cfg_we (write only)        i_cfg_idx, i_cfg_data
//
// one ray per cycle while the output is not stalled
// the pipe holds the two floor square roots (51 stages each, one root bit a stage)
// and the 18 stage restoring divider for the normals
// reset is synchronous, active low; it empties the pipe and loads the default sphere
// a stall on the output freezes every stage; o_in_ready is high when i_out_ready is high or o_out_valid is low
`default_nettype none
module ray_sphere_front_hit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [rsf_pkg::POS_W-1:0]      i_origin_x,
    input  logic signed [rsf_pkg::POS_W-1:0]      i_origin_y,
    input  logic signed [rsf_pkg::POS_W-1:0]      i_origin_z,
    input  logic signed [rsf_pkg::DIR_W-1:0]      i_dir_x,
    input  logic signed [rsf_pkg::DIR_W-1:0]      i_dir_y,
    input  logic signed [rsf_pkg::DIR_W-1:0]      i_dir_z,
    input  logic signed [rsf_pkg::POS_W-1:0]      i_t_near,
    input  logic signed [rsf_pkg::POS_W-1:0]      i_t_far,
    input  logic                                  i_light_mask_set,
    input  logic                                  i_ray_valid,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_hit,
    output logic signed [rsf_pkg::POS_W-1:0]      o_hit_distance,
    output logic signed [rsf_pkg::DIR_W-1:0]      o_normal_x,
    output logic signed [rsf_pkg::DIR_W-1:0]      o_normal_y,
    output logic signed [rsf_pkg::DIR_W-1:0]      o_normal_z,
    input  logic                                  i_cfg_we,
    input  logic [rsf_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [rsf_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    logic signed [rsf_pkg::POS_W-1:0] r_center_x, r_center_y, r_center_z;
    logic [rsf_pkg::RAD_W-1:0]        r_radius;

    logic                          en;
    logic                          f_vld, s1_vld, p_vld, s2_vld;
    logic [rsf_pkg::SQ_IN_W-1:0]   f_disc, p_rad;
    logic [rsf_pkg::SB_W-1:0]      f_sb, s1_sb, p_sb, s2_sb;
    logic [rsf_pkg::SQ_ROOT_W-1:0] s1_root, s2_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_radius   <= rsf_pkg::RADIUS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rsf_pkg::CFG_CENTER_X: r_center_x <= i_cfg_data;
                rsf_pkg::CFG_CENTER_Y: r_center_y <= i_cfg_data;
                rsf_pkg::CFG_CENTER_Z: r_center_z <= i_cfg_data;
                rsf_pkg::CFG_RADIUS:   r_radius   <= i_cfg_data[rsf_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipe advances together; the last stage is the output register
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    rsf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_vld            (i_in_valid),
        .i_origin_x       (i_origin_x),
        .i_origin_y       (i_origin_y),
        .i_origin_z       (i_origin_z),
        .i_dir_x          (i_dir_x),
        .i_dir_y          (i_dir_y),
        .i_dir_z          (i_dir_z),
        .i_t_near         (i_t_near),
        .i_t_far          (i_t_far),
        .i_light_mask_set (i_light_mask_set),
        .i_ray_valid      (i_ray_valid),
        .i_center_x       (r_center_x),
        .i_center_y       (r_center_y),
        .i_center_z       (r_center_z),
        .i_sphere_radius  (r_radius),
        .o_vld            (f_vld),
        .o_disc           (f_disc),
        .o_sb             (f_sb)
    );

    rsf_isqrt u_sqrt_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_rad   (f_disc),
        .i_sb    (f_sb),
        .o_vld   (s1_vld),
        .o_root  (s1_root),
        .o_sb    (s1_sb)
    );

    rsf_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s1_vld),
        .i_root  (s1_root),
        .i_sb    (s1_sb),
        .o_vld   (p_vld),
        .o_rad   (p_rad),
        .o_sb    (p_sb)
    );

    rsf_isqrt u_sqrt_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (p_vld),
        .i_rad   (p_rad),
        .i_sb    (p_sb),
        .o_vld   (s2_vld),
        .o_root  (s2_root),
        .o_sb    (s2_sb)
    );

    rsf_div u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_vld          (s2_vld),
        .i_root         (s2_root),
        .i_sb           (s2_sb),
        .o_vld          (o_out_valid),
        .o_hit          (o_hit),
        .o_hit_distance (o_hit_distance),
        .o_normal_x     (o_normal_x),
        .o_normal_y     (o_normal_y),
        .o_normal_z     (o_normal_z)
    );

    a_miss_zero_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0)
        else $error("miss beat carries a non-zero normal");

    // strict bounds mean a saturated distance can never be a hit
    a_hit_unsaturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> o_hit_distance != rsf_pkg::T_MAX
                              && o_hit_distance != rsf_pkg::T_MIN)
        else $error("hit reported at a saturated distance");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while the pipe is frozen");

endmodule
`default_nettype wire
